### rtl/sctg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctg_pkg
// shared types and constants of the sample count timestamp generator
// ----------------------------------------------------------------------------
package sctg_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 16;
    localparam int unsigned TS_W           = 63;
    localparam int unsigned POS_W          = 64;
    localparam int unsigned CNT_IN_W       = 20;
    localparam int unsigned RATE_W         = 22;
    localparam int unsigned NUM_W          = 94;
    localparam int unsigned DIV_CNT_W      = 7;
    localparam int unsigned PROD_W         = 62;
    localparam int unsigned S_TDATA_W      = 176;
    localparam int unsigned M_TDATA_W      = 72;

    localparam logic [PROD_W-1:0] NS_PER_SEC = PROD_W'(64'd1000000000);
    localparam logic [TS_W-1:0]   MAX63      = {TS_W{1'b1}};
    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);

    typedef enum logic [1:0] {
        CMD_ADD  = 2'd0,
        CMD_GET  = 2'd1,
        CMD_DROP = 2'd2,
        CMD_RATE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_IGNORED   = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_RATE_ZERO = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD,
        ST_GET_RD,
        ST_GET_CHK,
        ST_DROP_RD,
        ST_DROP_CHK,
        ST_RATE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_DIV,
        ST_SUM,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic             pos_valid;
        logic [POS_W-1:0] pos;
        logic [TS_W-1:0]  time_ns;
    } entry_t;

endpackage

### rtl/sctg_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctg_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module sctg_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/sample_count_timestamp_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_count_timestamp_generator_unit
// frame timestamp generator with a queue of known timestamps
// ----------------------------------------------------------------------------
// usage:
//   s_* carries one command request: s_tuser is the command, s_tdata holds
//   timestamp, its valid flag, position, its valid flag, sample count, rate.
//   m_* returns one result per request: m_tdata holds result_ns and status,
//   m_tuser the from_queue flag.
//   cfg_we/cfg_wdata write allow_smaller; the user must do so only while the
//   block is idle; the block itself does not enforce this.
// steps:
//   add checks and writes; get checks the queue head; drop checks entries
//   from the head until one matches or none is left; a calculated get or a
//   rate change does a 32-bit split multiply by 1e9, then a radix-2 divider
//   taking one quotient bit per cycle over 94 bits. one request is in work at
//   a time; queue ram read data is registered, read before each decision.
// reset:
//   queue empty, reference and sample count zero, rate 48000.
// stall:
//   a finished result waits in an output register; a new request is
//   accepted meanwhile and held before its own result until m_tready.
// ----------------------------------------------------------------------------
module sample_count_timestamp_generator_unit #(
    parameter int unsigned QUEUE_DEPTH = sctg_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // timestamp_ns, timestamp_valid, position, position_valid,
    // sample_count, sample_rate, zero fill
    input  logic [sctg_pkg::S_TDATA_W-1:0]   s_tdata,
    // command
    input  logic [1:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // result_ns, status, zero fill
    output logic [sctg_pkg::M_TDATA_W-1:0]   m_tdata,
    // from_queue
    output logic                             m_tuser,
    input  logic                             cfg_we,
    input  logic                             cfg_wdata
);
    import sctg_pkg::*;

    localparam int unsigned HEAD_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W:0] DEPTH_X = (CNT_W+1)'(QUEUE_DEPTH);

    state_t state_reg, state_next;

    // captured request
    cmd_t                cmd_reg;
    logic [TS_W-1:0]     ts_reg;
    logic                tsv_reg;
    logic [POS_W-1:0]    pos_reg;
    logic                posv_reg;
    logic [CNT_IN_W-1:0] cnt_reg;
    logic [RATE_W-1:0]   rate_reg;

    // block state
    logic                allow_reg;
    logic [HEAD_W-1:0]   head_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [TS_W-1:0]     tail_reg;
    logic [TS_W-1:0]     last_reg;
    logic                last_valid_reg;
    logic [TS_W-1:0]     ref_reg;
    logic [POS_W-1:0]    samples_reg;
    logic [RATE_W-1:0]   cur_rate_reg;

    // work registers
    logic [HEAD_W-1:0]   ptr_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [RATE_W-1:0]   rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    // pending result and output register
    logic [TS_W-1:0]     res_reg;
    logic                fromq_reg;
    status_t             status_reg;
    logic                m_valid_reg;
    logic [TS_W-1:0]     m_res_reg;
    logic                m_fromq_reg;
    status_t             m_status_reg;

    // ram
    logic                ram_we;
    logic [HEAD_W-1:0]   ram_waddr;
    logic [HEAD_W-1:0]   ram_raddr;
    entry_t              ram_wdata;
    entry_t              ram_rdata;

    logic                accept;
    logic                out_free;
    logic [CNT_W:0]      tail_sum;
    logic [HEAD_W-1:0]   tail_slot;
    logic [HEAD_W-1:0]   head_inc;
    logic [HEAD_W-1:0]   ptr_inc;
    logic                pass_last;
    logic                pass_tail;
    logic                add_ok;
    logic                pop_ok;
    logic                drop_hit;
    logic [RATE_W:0]     div_shift;
    logic                div_ge;
    logic [TS_W-1:0]     dur;
    logic [TS_W:0]       sum_wide;
    logic [TS_W-1:0]     sum_sat;

    sctg_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    always_comb
    begin
        tail_sum = (CNT_W+1)'(head_reg) + (CNT_W+1)'(count_reg);
        if (tail_sum >= DEPTH_X)
        begin
            tail_sum = tail_sum - DEPTH_X;
        end
        tail_slot = tail_sum[HEAD_W-1:0];
        head_inc  = (head_reg == HEAD_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        ptr_inc   = (ptr_reg == HEAD_W'(QUEUE_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
        pass_last = !last_valid_reg || (ts_reg > last_reg) ||
                    (allow_reg && (ts_reg < last_reg));
        pass_tail = (count_reg == '0) || (ts_reg > tail_reg) ||
                    (allow_reg && (ts_reg < tail_reg));
        add_ok    = tsv_reg && pass_last && pass_tail &&
                    (count_reg < CNT_W'(QUEUE_DEPTH));
        pop_ok    = (count_reg != '0) &&
                    (!posv_reg || !ram_rdata.pos_valid || (ram_rdata.pos <= pos_reg));
        drop_hit  = ram_rdata.pos_valid && (ram_rdata.pos >= pos_reg);
        div_shift = {rem_reg, num_reg[NUM_W-1]};
        div_ge    = div_shift >= {1'b0, cur_rate_reg};
        dur       = (|num_reg[NUM_W-1:TS_W]) ? MAX63 : num_reg[TS_W-1:0];
        sum_wide  = {1'b0, ref_reg} + {1'b0, dur};
        sum_sat   = sum_wide[TS_W] ? MAX63 : sum_wide[TS_W-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd_t'(s_tuser))
                        CMD_ADD:  state_next = ST_ADD;
                        CMD_GET:  state_next = ST_GET_RD;
                        CMD_DROP: state_next = ST_DROP_RD;
                        CMD_RATE: state_next = ST_RATE;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD:      state_next = ST_OUT;
            ST_GET_RD:   state_next = ST_GET_CHK;
            ST_GET_CHK:
            begin
                if (pop_ok || cur_rate_reg == '0)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_MUL_LO;
                end
            end
            ST_DROP_RD:  state_next = (idx_reg == count_reg) ? ST_OUT : ST_DROP_CHK;
            ST_DROP_CHK: state_next = drop_hit ? ST_OUT : ST_DROP_RD;
            ST_RATE:
            begin
                if (rate_reg == '0 || rate_reg == cur_rate_reg || cur_rate_reg == '0)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_MUL_LO;
                end
            end
            ST_MUL_LO:   state_next = ST_MUL_HI;
            ST_MUL_HI:   state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_cnt_reg == DIV_CNT_W'(NUM_W - 1))
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:      state_next = ST_OUT;
            ST_OUT:      state_next = out_free ? ST_IDLE : ST_OUT;
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready          = 1'b0;
        ram_we            = 1'b0;
        ram_waddr         = tail_slot;
        ram_raddr         = head_reg;
        ram_wdata.time_ns = ts_reg;
        ram_wdata.pos     = pos_reg;
        ram_wdata.pos_valid = posv_reg;
        unique case (state_reg)
            ST_IDLE:    s_tready  = 1'b1;
            ST_ADD:     ram_we    = add_ok;
            ST_DROP_RD: ram_raddr = ptr_reg;
            default:    ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            allow_reg    <= 1'b0;
            head_reg     <= '0;
            count_reg    <= '0;
            last_valid_reg <= 1'b0;
            last_reg     <= '0;
            ref_reg      <= '0;
            samples_reg  <= '0;
            cur_rate_reg <= RATE_RESET;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                allow_reg <= cfg_wdata;
            end
            if (state_reg == ST_OUT && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_ADD:
                begin
                    if (add_ok)
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
                ST_GET_CHK:
                begin
                    if (pop_ok)
                    begin
                        last_reg       <= ram_rdata.time_ns;
                        last_valid_reg <= 1'b1;
                        ref_reg        <= ram_rdata.time_ns;
                        samples_reg    <= POS_W'(cnt_reg);
                        head_reg       <= head_inc;
                        count_reg      <= count_reg - 1'b1;
                    end
                end
                ST_DROP_CHK:
                begin
                    if (drop_hit)
                    begin
                        head_reg  <= ptr_reg;
                        count_reg <= count_reg - idx_reg;
                    end
                end
                ST_RATE:
                begin
                    if (rate_reg != '0 && rate_reg != cur_rate_reg && cur_rate_reg == '0)
                    begin
                        samples_reg  <= '0;
                        cur_rate_reg <= rate_reg;
                    end
                end
                ST_SUM:
                begin
                    if (cmd_reg == CMD_GET)
                    begin
                        last_reg       <= sum_sat;
                        last_valid_reg <= 1'b1;
                        samples_reg    <= samples_reg + POS_W'(cnt_reg);
                    end
                    else
                    begin
                        ref_reg      <= sum_sat;
                        samples_reg  <= '0;
                        cur_rate_reg <= rate_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload and work registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= cmd_t'(s_tuser);
            ts_reg     <= s_tdata[62:0];
            tsv_reg    <= s_tdata[63];
            pos_reg    <= s_tdata[127:64];
            posv_reg   <= s_tdata[128];
            cnt_reg    <= s_tdata[148:129];
            rate_reg   <= s_tdata[170:149];
            res_reg    <= '0;
            fromq_reg  <= 1'b0;
            status_reg <= STATUS_OK;
            ptr_reg    <= head_reg;
            idx_reg    <= '0;
        end
        case (state_reg)
            ST_ADD:
            begin
                if (!tsv_reg || !pass_last || !pass_tail)
                begin
                    status_reg <= STATUS_IGNORED;
                end
                else if (!add_ok)
                begin
                    status_reg <= STATUS_FULL;
                end
                else
                begin
                    tail_reg <= ts_reg;
                end
            end
            ST_GET_CHK:
            begin
                if (pop_ok)
                begin
                    res_reg   <= ram_rdata.time_ns;
                    fromq_reg <= 1'b1;
                end
                else if (cur_rate_reg == '0)
                begin
                    status_reg <= STATUS_RATE_ZERO;
                end
            end
            ST_DROP_CHK:
            begin
                ptr_reg <= ptr_inc;
                idx_reg <= idx_reg + 1'b1;
            end
            ST_MUL_LO:
            begin
                prod_reg <= PROD_W'(samples_reg[31:0]) * NS_PER_SEC;
            end
            ST_MUL_HI:
            begin
                num_reg     <= NUM_W'(prod_reg) +
                               {PROD_W'(samples_reg[63:32]) * NS_PER_SEC, 32'b0};
                rem_reg     <= '0;
                div_cnt_reg <= '0;
            end
            ST_DIV:
            begin
                rem_reg     <= div_ge ? RATE_W'(div_shift - {1'b0, cur_rate_reg})
                                      : div_shift[RATE_W-1:0];
                num_reg     <= {num_reg[NUM_W-2:0], div_ge};
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            ST_SUM:
            begin
                if (cmd_reg == CMD_GET)
                begin
                    res_reg <= sum_sat;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    m_res_reg    <= res_reg;
                    m_fromq_reg  <= fromq_reg;
                    m_status_reg <= status_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_status_reg, m_res_reg};
    assign m_tuser  = m_fromq_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> count_reg != '0)
        else $error("queue write left count at zero");

    a_rate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_status_reg == STATUS_RATE_ZERO) |-> (m_res_reg == '0 && !m_fromq_reg))
        else $error("rate zero result carries a value");
`endif

endmodule

### tb/sv/sample_count_timestamp_generator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_count_timestamp_generator_unit_tb
// self-checking bench for the frame timestamp generator
// ----------------------------------------------------------------------------
// requests are driven over the stream input with random gaps while the
// result side stalls at random. a scoreboard class mirrors the queue,
// reference and rate, predicts every result and compares it field by field.
// a directed opening covers the edges, then mostly well-formed random
// traffic runs under each setting of allow_smaller.
// ----------------------------------------------------------------------------
module sample_count_timestamp_generator_unit_tb;

    import sctg_pkg::*;

    localparam int          QDEPTH     = 16;
    localparam longint      CYCLE_LIMIT = 2000000;
    localparam int          SETTLE      = 200;
    localparam logic [62:0] TOP_NS     = {63{1'b1}};
    localparam longint unsigned NS_SEC = 64'd1000000000;

    typedef struct {
        logic [62:0] result_ns;
        logic        from_queue;
        status_t     status;
    } stamp_t;

    class stamp_scoreboard;
        logic [62:0] q_time [QDEPTH];
        logic [63:0] q_pos [QDEPTH];
        logic        q_pos_ok [QDEPTH];
        int          head;
        int          count;
        logic [62:0] last_ns;
        logic        last_ok;
        logic [62:0] ref_ns;
        logic [63:0] samples;
        logic [21:0] rate;
        logic        allow_smaller;
        stamp_t      expected_stamps [$];
        int          errors;

        function new();
            head = 0; count = 0; last_ns = 0; last_ok = 0; ref_ns = 0;
            samples = 0; rate = 22'd48000; allow_smaller = 0; errors = 0;
        endfunction

        function logic [62:0] elapsed_ns(logic [63:0] s, logic [21:0] r);
            longint unsigned a, b, frac, whole;
            a = s / r;
            b = s % r;
            frac = (b * NS_SEC) / r;
            if (a > {1'b0, TOP_NS} / NS_SEC)
                return TOP_NS;
            whole = a * NS_SEC;
            if (whole > {1'b0, TOP_NS} - frac)
                return TOP_NS;
            return whole + frac;
        endfunction

        function logic [62:0] sum_sat(logic [62:0] x, logic [62:0] y);
            if ({1'b0, x} + {1'b0, y} > {1'b0, TOP_NS})
                return TOP_NS;
            return x + y;
        endfunction

        function bit above(logic [62:0] t, logic have, logic [62:0] lim);
            if (!have || t > lim)
                return 1;
            return allow_smaller && t < lim;
        endfunction

        function void note_request(cmd_t c, logic [62:0] ts, logic ts_ok,
                                   logic [63:0] pos, logic pos_ok,
                                   logic [19:0] cnt, logic [21:0] new_rate);
            stamp_t e;
            int s, i;
            e.result_ns = 0;
            e.from_queue = 0;
            e.status = STATUS_OK;
            case (c)
                CMD_ADD:
                begin
                    if (!ts_ok)
                        e.status = STATUS_IGNORED;
                    else if (!above(ts, last_ok, last_ns) ||
                             !above(ts, count > 0,
                                    q_time[(head + count + QDEPTH - 1) % QDEPTH]))
                        e.status = STATUS_IGNORED;
                    else if (count >= QDEPTH)
                        e.status = STATUS_FULL;
                    else
                    begin
                        s = (head + count) % QDEPTH;
                        q_time[s] = ts;
                        q_pos[s] = pos;
                        q_pos_ok[s] = pos_ok;
                        count++;
                    end
                end
                CMD_GET:
                begin
                    if (count > 0 && (!pos_ok || !q_pos_ok[head] || q_pos[head] <= pos))
                    begin
                        e.result_ns = q_time[head];
                        e.from_queue = 1;
                        last_ns = q_time[head];
                        last_ok = 1;
                        ref_ns = q_time[head];
                        samples = cnt;
                        head = (head + 1) % QDEPTH;
                        count--;
                    end
                    else if (rate == 0)
                        e.status = STATUS_RATE_ZERO;
                    else
                    begin
                        e.result_ns = sum_sat(ref_ns, elapsed_ns(samples, rate));
                        last_ns = e.result_ns;
                        last_ok = 1;
                        samples += cnt;
                    end
                end
                CMD_DROP:
                begin
                    for (i = 0; i < count; i++)
                    begin
                        s = (head + i) % QDEPTH;
                        if (q_pos_ok[s] && q_pos[s] >= pos)
                            break;
                    end
                    if (i < count)
                    begin
                        head = (head + i) % QDEPTH;
                        count -= i;
                    end
                end
                default:
                begin
                    if (new_rate != 0 && new_rate != rate)
                    begin
                        if (rate != 0)
                            ref_ns = sum_sat(ref_ns, elapsed_ns(samples, rate));
                        samples = 0;
                        rate = new_rate;
                    end
                end
            endcase
            expected_stamps.push_back(e);
        endfunction

        function void check_result(logic [62:0] res, logic fq, logic [1:0] st);
            stamp_t e;
            if (expected_stamps.size() == 0)
            begin
                $display("%0t: unexpected result ns=%0d from_queue=%0d status=%0d",
                         $time, res, fq, st);
                errors++;
                return;
            end
            e = expected_stamps[0];
            expected_stamps.delete(0);
            if (res !== e.result_ns)
            begin
                $display("%0t: result_ns expected %0d actual %0d", $time, e.result_ns, res);
                errors++;
            end
            if (fq !== e.from_queue)
            begin
                $display("%0t: from_queue expected %0d actual %0d", $time, e.from_queue, fq);
                errors++;
            end
            if (st !== e.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, st);
                errors++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [175:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [71:0]  m_tdata;
    logic         m_tuser;
    logic         cfg_we;
    logic         cfg_wdata;

    stamp_scoreboard sb;
    longint          cycles;
    bit              calm;
    int              stall_left;
    logic [62:0]     next_ns;
    logic [63:0]     next_pos;

    sample_count_timestamp_generator_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 0;
    end

    always #6 clk = ~clk;

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 45)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            m_tready <= 0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            m_tready <= 1;
            stall_left <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata[62:0], m_tuser, m_tdata[64:63]);
    end

    task automatic send_req(cmd_t c, logic [62:0] ts, logic ts_ok, logic [63:0] pos,
                            logic pos_ok, logic [19:0] cnt, logic [21:0] new_rate);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser <= c;
        s_tdata <= {5'b0, new_rate, cnt, pos_ok, pos, ts_ok, ts};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(c, ts, ts_ok, pos, pos_ok, cnt, new_rate);
    endtask

    task automatic wait_drained();
        s_tvalid <= 0;
        while (sb.expected_stamps.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_allow_smaller(logic v);
        wait_drained();
        cfg_we <= 1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 0;
        sb.allow_smaller = v;
    endtask

    task automatic random_req();
        int r;
        logic [63:0] w;
        r = $urandom_range(0, 99);
        w = {$urandom, $urandom};
        if (r < 35)
        begin
            next_ns += $urandom_range(1, 30000000);
            send_req(CMD_ADD, next_ns, $urandom_range(0, 19) != 0,
                     next_pos + $urandom_range(0, 4000), $urandom_range(0, 4) != 0,
                     20'($urandom), 22'($urandom));
        end
        else if (r < 68)
        begin
            next_pos += $urandom_range(0, 2000);
            send_req(CMD_GET, 63'($urandom), 1'($urandom_range(0, 1)), next_pos,
                     $urandom_range(0, 3) != 0,
                     ($urandom_range(0, 9) == 0) ? 20'($urandom) : 20'($urandom_range(1, 2048)),
                     22'($urandom));
        end
        else if (r < 75)
            send_req(CMD_DROP, 63'($urandom), 1'($urandom_range(0, 1)),
                     next_pos + $urandom_range(0, 6000), 1'($urandom_range(0, 1)),
                     20'($urandom), 22'($urandom));
        else if (r < 82)
            send_req(CMD_RATE, 63'($urandom), 1'($urandom_range(0, 1)), w,
                     1'($urandom_range(0, 1)),
                     20'($urandom),
                     ($urandom_range(0, 4) == 0) ? 22'($urandom) :
                     22'($urandom_range(0, 2) * 4000 + 44100));
        else
            send_req(cmd_t'($urandom_range(0, 3)), 63'({$urandom, $urandom}),
                     1'($urandom_range(0, 1)),
                     w, 1'($urandom_range(0, 1)), 20'($urandom), 22'($urandom));
    endtask

    task automatic random_phase(int n);
        int k;
        for (k = 0; k < n; k++)
        begin
            if (k % 60 == 0)
                calm = !calm;
            random_req();
        end
    endtask

    initial
    begin
        sb = new();
        cycles = 0;
        calm = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = CMD_ADD;
        cfg_we = 0;
        cfg_wdata = 0;
        next_ns = 63'd1000;
        next_pos = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // edges of each command
        send_req(CMD_ADD, 63'd5, 0, 64'd100, 1, 0, 0);
        send_req(CMD_ADD, 63'd5, 1, 64'd100, 1, 0, 0);
        send_req(CMD_ADD, 63'd5, 1, 64'd200, 1, 0, 0);
        send_req(CMD_ADD, 63'd3, 1, 64'd300, 0, 0, 0);
        send_req(CMD_GET, 0, 0, 64'd50, 1, 20'd480, 0);
        send_req(CMD_GET, 0, 0, 64'd100, 1, 20'hFFFFF, 0);
        send_req(CMD_GET, 0, 0, 0, 0, 20'd1000, 0);
        send_req(CMD_RATE, 0, 0, 0, 0, 0, 22'd0);
        send_req(CMD_RATE, 0, 0, 0, 0, 0, 22'd48000);
        send_req(CMD_RATE, 0, 0, 0, 0, 0, 22'h3FFFFF);
        send_req(CMD_GET, 0, 0, 0, 0, 20'hFFFFF, 0);
        send_req(CMD_RATE, 0, 0, 0, 0, 0, 22'd1);
        send_req(CMD_GET, 0, 0, 0, 0, 20'hFFFFF, 0);
        send_req(CMD_ADD, 63'd7000000000, 1, 64'd10, 1, 0, 0);
        send_req(CMD_ADD, TOP_NS - 1, 1, {64{1'b1}}, 1, 0, 0);
        send_req(CMD_ADD, TOP_NS, 1, 64'd20, 0, 0, 0);
        send_req(CMD_DROP, 0, 0, 64'd0, 0, 0, 0);
        send_req(CMD_DROP, 0, 0, {64{1'b1}}, 1, 0, 0);
        send_req(CMD_GET, 0, 0, 0, 1, 20'd5, 0);
        send_req(CMD_GET, 0, 0, {64{1'b1}}, 1, 20'd5, 0);
        send_req(CMD_GET, 0, 0, 0, 0, 20'hFFFFF, 0);
        send_req(CMD_GET, 0, 0, 0, 0, 20'd1, 0);
        send_req(CMD_DROP, 0, 0, {64{1'b1}}, 0, 0, 0);

        // back from saturation with smaller values allowed
        write_allow_smaller(1);
        send_req(CMD_ADD, TOP_NS, 1, 0, 0, 0, 0);
        send_req(CMD_ADD, 63'd1000, 1, 64'd0, 1, 0, 0);
        send_req(CMD_GET, 0, 0, 0, 0, 20'd0, 0);
        send_req(CMD_RATE, 0, 0, 0, 0, 0, 22'd48000);
        for (int k = 0; k < QDEPTH + 2; k++)
            send_req(CMD_ADD, 63'd2000 + 63'(k) * 1000, 1, 64'(k) * 64, 1, 0, 0);
        wait_drained();
        random_phase(130);

        write_allow_smaller(0);
        next_ns = sb.last_ns + 1;
        next_pos = 0;
        random_phase(140);

        write_allow_smaller(1);
        random_phase(140);

        wait_drained();
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
